[hdl/rsa_pkg.sv]
// Shared types and constants for the ring scratch allocator.
// No dependencies; compile first.
package rsa_pkg;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    localparam logic [1:0] KIND_IN   = 2'd0;
    localparam logic [1:0] KIND_NULL = 2'd1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_BACKING = 2'd2;

    localparam logic [15:0] PAD_MARK  = 16'hFFFF;
    localparam logic [15:0] FREE_MARK = 16'h8000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_WRAP,
        S_HDR,
        S_PAD,
        S_FIND_RD,
        S_FIND_CHK,
        S_MARK,
        S_WALK_RD,
        S_WALK_CHK,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic wr_filler;
        logic wr_hdr;
        logic wr_pad;
        logic find_rd;
        logic find_step;
        logic do_query;
        logic wr_mark;
        logic walk_rd;
        logic walk_adv;
        logic set_back;
        logic set_null;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic is_fq;
        logic is_query;
        logic ptr_null;
        logic ptr_bad;
        logic no_fit;
        logic wrap;
        logic pad_done;
        logic find_zero;
        logic find_pad;
        logic walk_stop;
        logic walk_ok;
    } dp_sts_t;

endpackage

[hdl/rsa_if.sv]
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on nothing.
interface rsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] req_size;
    logic [6:0]  req_align;
    logic [11:0] data_offset;
    logic [1:0]  ptr_kind;
    modport source (output valid, req_type, req_size, req_align, data_offset, ptr_kind,
                    input ready);
    modport sink (input valid, req_type, req_size, req_align, data_offset, ptr_kind,
                  output ready);
endinterface

interface rsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] block_offset;
    logic        to_backing;
    logic [11:0] usable_bytes;
    logic [1:0]  status;
    modport source (output valid, block_offset, to_backing, usable_bytes, status,
                    input ready);
    modport sink (input valid, block_offset, to_backing, usable_bytes, status,
                  output ready);
endinterface

interface rsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hdl/rsa_datapath.sv]
// Datapath: request registers, ring pointers, header memory, result fields.
// Depends on rsa_pkg.
module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int BUF_WORDS = 1024,
    parameter int MAX_ALIGN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic        cfg_we,
    input  logic [12:0] cfg_data,
    input  logic [1:0]  in_type,
    input  logic [11:0] in_size,
    input  logic [6:0]  in_align,
    input  logic [11:0] in_off,
    input  logic [1:0]  in_kind,
    output logic [11:0] block_offset,
    output logic        to_backing,
    output logic [11:0] usable_bytes,
    output logic [1:0]  status
);
    localparam int AW = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
    localparam int PW = 16; // byte positions, wide enough for all sums
    localparam logic [PW-1:0] MAX_BYTES = PW'(BUF_WORDS * 4);
    localparam logic [PW-1:0] MAXA = PW'(MAX_ALIGN);

    logic [15:0] mem [BUF_WORDS];
    logic [15:0] rd_reg;

    logic [PW-1:0] buf_reg, alloc_reg, free_reg;
    logic [1:0]  type_reg, kind_reg;
    logic [PW-1:0] size_reg, al_reg, off_reg;
    logic [PW-1:0] data_reg, end_reg, h_reg, wp_reg, w_reg;
    logic          wrap_reg, nofit_reg;
    logic [11:0] blk_reg, use_reg;
    logic        back_reg;
    logic [1:0]  st_reg;

    // effective alignment: largest power of two not above req, at least 4, clamped to MAX_ALIGN
    logic [PW-1:0] al_eff;
    always_comb
    begin
        al_eff = PW'(4);
        for (int i = 3; i <= 8; i++)
        begin
            if ((PW'(1) << i) <= PW'(in_align) && (PW'(1) << i) <= MAXA)
                al_eff = PW'(1) << i;
        end
    end

    // clamp configured size
    logic [PW-1:0] cfg_b;
    always_comb
    begin
        cfg_b = PW'({cfg_data[12:2], 2'b00});
        if (cfg_b > MAX_BYTES)
            cfg_b = MAX_BYTES;
        if (cfg_b < PW'(16))
            cfg_b = PW'(16);
    end

    // allocation evaluation
    logic [PW-1:0] amask, d1, e1, d2, e2, space, dist_af, dist_fa, dd, fin_d, fin_e;
    logic          wr1, bad;
    always_comb
    begin
        amask = al_reg - PW'(1);
        d1 = (alloc_reg + PW'(4) + amask) & ~amask;
        e1 = d1 + size_reg;
        d2 = (PW'(4) + amask) & ~amask;
        e2 = d2 + size_reg;
        wr1 = (e1 > buf_reg) || (d1 >= buf_reg);
        fin_d = wr1 ? d2 : d1;
        fin_e = wr1 ? e2 : e1;
        dd = wr1 ? (buf_reg - alloc_reg + e2) : (e1 - alloc_reg);
        dist_af = (free_reg >= alloc_reg) ? free_reg - alloc_reg
                                          : buf_reg - alloc_reg + free_reg;
        space = (alloc_reg == free_reg) ? buf_reg : dist_af;
        bad = (dd >= space) || (fin_e > buf_reg) || (fin_d >= buf_reg);
        dist_fa = (alloc_reg >= free_reg) ? alloc_reg - free_reg
                                          : buf_reg - free_reg + alloc_reg;
    end

    // walk check on read header at free_pos
    logic [14:0] wlen;
    logic        wstop;
    logic [PW-1:0] fnext;
    always_comb
    begin
        wlen = rd_reg[14:0];
        wstop = (free_reg == alloc_reg) || !rd_reg[15] || (wlen == 15'd0)
                || (wlen[1:0] != 2'b00) || (PW'(wlen) > dist_fa);
        fnext = free_reg + PW'(wlen);
        if (fnext >= buf_reg)
            fnext = fnext - buf_reg;
    end

    logic [AW-1:0] rd_addr;
    logic          rd_en;
    always_comb
    begin
        rd_en = cmd.find_rd || cmd.walk_rd;
        rd_addr = cmd.walk_rd ? free_reg[AW+1:2] : AW'(w_reg - PW'(1));
    end

    // memory write port
    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (cmd.wr_filler)
        begin
            we = 1'b1;
            wa = alloc_reg[AW+1:2];
            wd = FREE_MARK | 16'(buf_reg - alloc_reg);
        end
        else if (cmd.wr_hdr)
        begin
            we = 1'b1;
            wa = h_reg[AW+1:2];
            wd = 16'(end_reg - h_reg);
        end
        else if (cmd.wr_pad)
        begin
            we = 1'b1;
            wa = wp_reg[AW+1:2];
            wd = PAD_MARK;
        end
        else if (cmd.wr_mark)
        begin
            we = 1'b1;
            wa = AW'(w_reg - PW'(1));
            wd = rd_reg | FREE_MARK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    logic [PW-1:0] gap;
    assign gap = off_reg - ((w_reg - PW'(1)) << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= MAX_BYTES < PW'(4096) ? MAX_BYTES : PW'(4096);
            alloc_reg <= '0;
            free_reg  <= '0;
        end
        else if (cfg_we)
        begin
            buf_reg   <= cfg_b;
            alloc_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            if (cmd.wr_hdr)
                alloc_reg <= (end_reg >= buf_reg) ? '0 : end_reg;
            if (cmd.walk_adv)
                free_reg <= fnext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= in_type;
            kind_reg <= in_kind;
            size_reg <= (PW'(in_size) + PW'(3)) & ~PW'(3);
            al_reg   <= al_eff;
            off_reg  <= PW'(in_off);
            w_reg    <= PW'(in_off[11:2]);
            blk_reg  <= '0;
            use_reg  <= '0;
            back_reg <= 1'b0;
            st_reg   <= ST_DONE;
        end
        if (cmd.eval)
        begin
            data_reg  <= fin_d;
            end_reg   <= fin_e;
            wrap_reg  <= wr1;
            nofit_reg <= bad;
            h_reg     <= wr1 ? '0 : alloc_reg;
            wp_reg    <= (wr1 ? PW'(0) : alloc_reg) + PW'(4);
        end
        if (cmd.wr_hdr)
            blk_reg <= 12'(data_reg);
        if (cmd.wr_pad)
            wp_reg <= wp_reg + PW'(4);
        if (cmd.find_step)
            w_reg <= w_reg - PW'(1);
        if (cmd.do_query)
            use_reg <= (PW'(rd_reg[14:0]) > gap) ? 12'(PW'(rd_reg[14:0]) - gap) : '0;
        if (cmd.set_back)
        begin
            back_reg <= 1'b1;
            st_reg   <= ST_BACKING;
        end
        if (cmd.set_null)
            st_reg <= ST_NULL;
    end

    always_comb
    begin
        sts.is_alloc  = (type_reg == REQ_ALLOC);
        sts.is_fq     = (type_reg == REQ_FREE) || (type_reg == REQ_QUERY);
        sts.is_query  = (type_reg == REQ_QUERY);
        sts.ptr_null  = (kind_reg == KIND_NULL);
        sts.ptr_bad   = (kind_reg != KIND_IN) || (off_reg >= buf_reg);
        sts.no_fit    = nofit_reg;
        sts.wrap      = wrap_reg;
        sts.pad_done  = (wp_reg >= data_reg);
        sts.find_zero = (w_reg == '0);
        sts.find_pad  = (rd_reg == PAD_MARK);
        sts.walk_stop = wstop;
        sts.walk_ok   = !wstop;
    end

    assign block_offset = blk_reg;
    assign to_backing   = back_reg;
    assign usable_bytes = use_reg;
    assign status       = st_reg;

`ifndef SYNTH
    a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg[1:0] == 2'b00) else $error("alloc_pos not word aligned");
    a_free_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg[1:0] == 2'b00) else $error("free_pos not word aligned");
    a_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg < buf_reg && free_reg < buf_reg) else $error("pointer past ring end");
`endif
endmodule

[hdl/rsa_ctrl.sv]
// Controller state machine sequencing allocate, free and query requests.
// Depends on rsa_pkg.
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.is_alloc)
                    state_next = S_WRAP;
                else if (!sts.is_fq)
                    state_next = S_OUT;
                else if (sts.ptr_null)
                begin
                    cmd.set_null = 1'b1;
                    state_next = S_OUT;
                end
                else if (sts.ptr_bad)
                begin
                    cmd.set_back = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_FIND_CHK;
            end
            S_WRAP:
            begin
                if (sts.no_fit)
                begin
                    cmd.set_back = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.wr_filler = sts.wrap;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                cmd.wr_hdr = 1'b1;
                state_next = S_PAD;
            end
            S_PAD:
            begin
                if (sts.pad_done)
                    state_next = S_OUT;
                else
                    cmd.wr_pad = 1'b1;
            end
            S_FIND_CHK:
            begin
                if (sts.find_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.find_rd = 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                if (sts.find_pad)
                begin
                    cmd.find_step = 1'b1;
                    state_next = S_FIND_CHK;
                end
                else if (sts.is_query)
                begin
                    cmd.do_query = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_MARK;
            end
            S_MARK:
            begin
                cmd.wr_mark = 1'b1;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (sts.walk_ok)
                begin
                    cmd.walk_adv = 1'b1;
                    state_next = S_WALK_RD;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
`endif
endmodule

[hdl/ring_scratch_allocator.sv]
// Ring scratch allocator top level: controller plus datapath.
// Allocate writes a filler header on wrap, then the header and its pad words, or passes
// the request to backing; query and free walk back over pad words to the header, and free
// then marks it freed and advances past freed slots.
// Throughput: one request at a time; the next is taken after the result beat.
// Reset: asynchronous active low; ring empty, size 4096 bytes; headers undefined.
module ring_scratch_allocator
    import rsa_pkg::*;
#(
    parameter int BUF_WORDS = 1024,
    parameter int MAX_ALIGN = 64
) (
    input logic   clk,
    input logic   rst_n,
    rsa_req_if.sink   req,
    rsa_rsp_if.source rsp,
    rsa_cfg_if.sink   cfg
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    // configuration is taken any time; user writes only while idle
    assign cfg.ready = 1'b1;

    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rsa_datapath #(
        .BUF_WORDS (BUF_WORDS),
        .MAX_ALIGN (MAX_ALIGN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.data),
        .in_type      (req.req_type),
        .in_size      (req.req_size),
        .in_align     (req.req_align),
        .in_off       (req.data_offset),
        .in_kind      (req.ptr_kind),
        .block_offset (rsp.block_offset),
        .to_backing   (rsp.to_backing),
        .usable_bytes (rsp.usable_bytes),
        .status       (rsp.status)
    );
endmodule

[bench/ring_scratch_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for ring_scratch_allocator: random and directed requests, predicted
// results checked beat by beat. Depends on ring_scratch_allocator, rsa_pkg and rsa_*_if.
module ring_scratch_allocator_tb;
    import rsa_pkg::*;

    localparam int RING_WORDS = 1024;
    localparam int ALIGN_CAP  = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [11:0] size;
        logic [6:0]  align;
        logic [11:0] offset;
        logic [1:0]  kind;
    } alloc_req_t;

    typedef struct packed {
        logic [11:0] blk;
        logic        back;
        logic [11:0] usable;
        logic [1:0]  st;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;

    rsa_req_if req_ch();
    rsa_rsp_if rsp_ch();
    rsa_cfg_if cfg_ch();

    ring_scratch_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Shadow of the allocator: header words, which of them hold a written value,
    // and the two ring pointers plus the configured ring size.
    bit [15:0]   hdr_mem [RING_WORDS];
    bit          hdr_set [RING_WORDS];
    int unsigned alloc_ptr;
    int unsigned free_ptr;
    int unsigned ring_bytes;

    alloc_req_t  pending_reqs [$];
    alloc_rsp_t  expected_rsps [$];
    int unsigned live_blocks [$];

    int err_cnt;
    int req_beats;
    int rsp_beats;
    int cfg_beats;
    int backing_cnt;
    bit calm;

    // Bytes from a to b going forward round the ring.
    function automatic int unsigned ring_dist(int unsigned a, int unsigned b);
        return (b >= a) ? b - a : ring_bytes - a + b;
    endfunction

    // Walk back over pad words to the header; 0 means no header found.
    function automatic int unsigned header_word(int unsigned off);
        int unsigned w;
        w = off >> 2;
        while (w > 0 && hdr_mem[w - 1] == PAD_MARK)
            w--;
        return w;
    endfunction

    // True when the backward header walk only touches words already written.
    function automatic bit walk_is_defined(int unsigned off);
        int unsigned w;
        w = off >> 2;
        while (w > 0)
        begin
            if (!hdr_set[w - 1])
                return 0;
            if (hdr_mem[w - 1] != PAD_MARK)
                return 1;
            w--;
        end
        return 1;
    endfunction

    function automatic void write_hdr(int unsigned w, bit [15:0] v);
        hdr_mem[w] = v;
        hdr_set[w] = 1'b1;
    endfunction

    function automatic void apply_ring_size(bit [12:0] v);
        int unsigned b;
        b = int'(v) & 32'hFFFF_FFFC;
        if (b > RING_WORDS * 4)
            b = RING_WORDS * 4;
        if (b < 16)
            b = 16;
        ring_bytes = b;
        alloc_ptr  = 0;
        free_ptr   = 0;
    endfunction

    // Advance the shadow by one request and return the result it must give.
    function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
        alloc_rsp_t  e;
        int unsigned sz, al, off, h, data, fin, d, space, w, hi, len, gap, hv;
        bit          wrap;
        e    = '0;
        sz   = (int'(r.size) + 3) & 32'hFFFF_FFFC;
        off  = r.offset;
        al   = 4;
        while (al * 2 <= int'(r.align) && al * 2 <= ALIGN_CAP)
            al *= 2;
        wrap = 0;
        if (r.rtype == REQ_ALLOC)
        begin
            h    = alloc_ptr;
            data = (h + 4 + al - 1) & ~(al - 1);
            fin  = data + sz;
            if (fin > ring_bytes || data >= ring_bytes)
            begin
                wrap = 1;
                data = (4 + al - 1) & ~(al - 1);
                fin  = data + sz;
            end
            d     = wrap ? (ring_bytes - h) + fin : fin - h;
            space = (alloc_ptr == free_ptr) ? ring_bytes : ring_dist(alloc_ptr, free_ptr);
            if (d >= space || fin > ring_bytes || data >= ring_bytes)
            begin
                e.back = 1'b1;
                e.st   = ST_BACKING;
            end
            else
            begin
                if (wrap)
                begin
                    write_hdr(h >> 2, FREE_MARK | 16'(ring_bytes - h));
                    h = 0;
                end
                write_hdr(h >> 2, 16'(fin - h));
                for (w = (h >> 2) + 1; w < (data >> 2); w++)
                    write_hdr(w, PAD_MARK);
                alloc_ptr = (fin >= ring_bytes) ? 0 : fin;
                e.blk = 12'(data);
            end
        end
        else if (r.rtype == REQ_FREE || r.rtype == REQ_QUERY)
        begin
            if (r.kind == KIND_NULL)
                e.st = ST_NULL;
            else if (r.kind != KIND_IN || off >= ring_bytes)
            begin
                e.back = 1'b1;
                e.st   = ST_BACKING;
            end
            else
            begin
                w = header_word(off);
                if (w != 0)
                begin
                    hi = w - 1;
                    if (r.rtype == REQ_QUERY)
                    begin
                        len = hdr_mem[hi] & 16'h7FFF;
                        gap = off - hi * 4;
                        e.usable = (len > gap) ? 12'(len - gap) : 12'd0;
                    end
                    else
                    begin
                        write_hdr(hi, hdr_mem[hi] | FREE_MARK);
                        // Advance past freed slots; stop at the first live or bad one.
                        while (free_ptr != alloc_ptr)
                        begin
                            hv  = hdr_mem[free_ptr >> 2];
                            len = hv & 16'h7FFF;
                            if ((hv & FREE_MARK) == 0)
                                break;
                            if (len == 0 || (len & 3) != 0 ||
                                len > ring_dist(free_ptr, alloc_ptr))
                                break;
                            free_ptr += len;
                            if (free_ptr >= ring_bytes)
                                free_ptr -= ring_bytes;
                        end
                    end
                end
            end
        end
        return e;
    endfunction

    // Queue one request with its expected result; a lookup that would read an
    // unwritten header word is turned into a null-pointer request instead.
    task automatic push_req(alloc_req_t r);
        alloc_rsp_t e;
        if ((r.rtype == REQ_FREE || r.rtype == REQ_QUERY) && r.kind == KIND_IN &&
            int'(r.offset) < ring_bytes && !walk_is_defined(r.offset))
            r.kind = KIND_NULL;
        e = predict_alloc(r);
        if (r.rtype == REQ_ALLOC && !e.back)
            live_blocks.push_back(e.blk);
        pending_reqs.push_back(r);
        expected_rsps.push_back(e);
    endtask

    task automatic push_fields(bit [1:0] t, int sz, int al, int off, bit [1:0] k);
        alloc_req_t r;
        r.rtype  = t;
        r.size   = 12'(sz);
        r.align  = 7'(al);
        r.offset = 12'(off);
        r.kind   = k;
        push_req(r);
    endtask

    // One random request, biased toward well-formed alloc/free/query traffic.
    task automatic push_random();
        int unsigned pick, idx, blk;
        alloc_req_t  r;
        pick = $urandom_range(0, 99);
        r.rtype  = REQ_ALLOC;
        r.size   = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, ring_bytes / 6))
                                              : 12'($urandom_range(0, 4095));
        r.align  = 7'($urandom_range(0, 127));
        r.offset = 12'($urandom_range(0, 4095));
        r.kind   = KIND_IN;
        if (pick < 45 || (pick < 85 && live_blocks.size() == 0))
        begin
            r.rtype = REQ_ALLOC;
        end
        else if (pick < 70)
        begin
            // free mostly the oldest block so the free pointer keeps moving
            idx = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, live_blocks.size() - 1);
            r.rtype  = REQ_FREE;
            r.offset = 12'(live_blocks[idx]);
            live_blocks.delete(idx);
        end
        else if (pick < 85)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[idx];
            r.rtype  = REQ_QUERY;
            r.offset = 12'(blk + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0));
        end
        else
        begin
            r.rtype = 2'($urandom_range(0, 3));
            r.kind  = 2'($urandom_range(0, 3));
        end
        push_req(r);
    endtask

    // Hold until every queued request is sent and every result has come back.
    task automatic drain();
        wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_ring_size(bit [12:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_beats++;
        apply_ring_size(v);
        live_blocks.delete();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        err_cnt++;
    endtask

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Request driver: hold the beat until taken, then idle a drawn number of cycles.
    logic req_taken;
    logic rsp_taken;
    int   req_gap;
    int   rsp_stall;

    always @(posedge clk)
    begin
        req_taken <= req_ch.valid && req_ch.ready;
        rsp_taken <= rsp_ch.valid && rsp_ch.ready;
    end

    always @(negedge clk)
    begin
        alloc_req_t r;
        if (rst_n && !(req_ch.valid && !req_taken))
        begin
            if (req_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap--;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                req_ch.req_type    <= r.rtype;
                req_ch.req_size    <= r.size;
                req_ch.req_align   <= r.align;
                req_ch.data_offset <= r.offset;
                req_ch.ptr_kind    <= r.kind;
                req_ch.valid       <= 1'b1;
                req_gap = draw_wait();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: stall a drawn number of cycles after each beat.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
                rsp_stall = draw_wait();
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_rsp_t e;
        if (rst_n && req_ch.valid && req_ch.ready)
            req_beats++;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_beats++;
            if (expected_rsps.size() == 0)
            begin
                $display("[%0t] result beat with nothing expected", $time);
                err_cnt++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (e.back)
                    backing_cnt++;
                if (rsp_ch.block_offset !== e.blk)
                    report_mismatch("block_offset", rsp_ch.block_offset, e.blk);
                if (rsp_ch.to_backing !== e.back)
                    report_mismatch("to_backing", rsp_ch.to_backing, e.back);
                if (rsp_ch.usable_bytes !== e.usable)
                    report_mismatch("usable_bytes", rsp_ch.usable_bytes, e.usable);
                if (rsp_ch.status !== e.st)
                    report_mismatch("status", rsp_ch.status, e.st);
            end
        end
    end

    // Watchdog: drop the run when no beat moves for too long.
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        bit [12:0] sizes [8];
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_NOP;
        req_ch.req_size = '0;
        req_ch.req_align = '0;
        req_ch.data_offset = '0;
        req_ch.ptr_kind = KIND_NULL;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        req_gap = 0;
        rsp_stall = 0;
        idle_cycles = 0;
        err_cnt = 0;
        req_beats = 0;
        rsp_beats = 0;
        cfg_beats = 0;
        backing_cnt = 0;
        calm = 1'b0;
        foreach (hdr_set[i])
        begin
            hdr_set[i] = 1'b0;
            hdr_mem[i] = '0;
        end
        apply_ring_size(13'd4096);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed traffic on the reset ring size.
        push_fields(REQ_ALLOC, 0, 4, 0, KIND_IN);
        push_fields(REQ_ALLOC, 1, 64, 0, KIND_IN);
        push_fields(REQ_QUERY, 0, 0, 72, KIND_IN);
        push_fields(REQ_QUERY, 0, 0, 68, KIND_IN);
        push_fields(REQ_QUERY, 0, 0, 64, KIND_IN);
        push_fields(REQ_ALLOC, 4095, 127, 0, KIND_IN);
        push_fields(REQ_ALLOC, 100, 0, 0, KIND_IN);
        push_fields(REQ_FREE, 0, 0, 4, KIND_NULL);
        push_fields(REQ_QUERY, 0, 0, 4, KIND_NULL);
        push_fields(REQ_FREE, 0, 0, 4, 2'd2);
        push_fields(REQ_QUERY, 0, 0, 4, 2'd3);
        push_fields(REQ_QUERY, 0, 0, 4095, KIND_IN);
        push_fields(REQ_NOP, 4095, 127, 4095, 2'd3);
        push_fields(REQ_FREE, 0, 0, 64, KIND_IN);
        push_fields(REQ_FREE, 0, 0, 64, KIND_IN);
        push_fields(REQ_FREE, 0, 0, 4, KIND_IN);
        push_fields(REQ_ALLOC, 2000, 8, 0, KIND_IN);
        push_fields(REQ_ALLOC, 1800, 32, 0, KIND_IN);
        push_fields(REQ_FREE, 0, 0, 4, KIND_IN);
        push_fields(REQ_ALLOC, 1500, 16, 0, KIND_IN);
        push_fields(REQ_QUERY, 0, 0, 4, KIND_IN);
        push_fields(REQ_ALLOC, 3000, 4, 0, KIND_IN);
        drain();

        // Random phases, one ring size each, extremes included.
        sizes = '{13'd16, 13'd8191, 13'd0, 13'd4096, 13'd301, 13'd17, 13'd1024, 13'd64};
        foreach (sizes[p])
        begin
            write_ring_size(sizes[p]);
            calm = (p % 3 == 2);
            repeat (55)
                push_random();
            // pause the sender until the ring has answered everything so far
            drain();
            repeat (55)
                push_random();
            drain();
        end
        repeat (50) @(posedge clk);

        $display("Sent %0d requests over %0d ring sizes; %0d results checked, %0d to backing.",
                 req_beats, cfg_beats, rsp_beats, backing_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hdl/rsa_pkg.sv
hdl/rsa_if.sv
hdl/rsa_datapath.sv
hdl/rsa_ctrl.sv
hdl/ring_scratch_allocator.sv
bench/ring_scratch_allocator_tb.sv
